/* rtl/lruc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_pkg: shared types and constants
// Geometry, command and result records, state codes and the LRU update.
// ----------------------------------------------------------------------------
package lruc_pkg;

  localparam int MAX_LOG_SETS     = 11;
  localparam int MAX_WAYS         = 8;
  localparam int MAX_LOG_PHYS_MEM = 16;

  localparam int NUM_SETS    = 1 << MAX_LOG_SETS;
  localparam int OWNER_DEPTH = 1 << (MAX_LOG_PHYS_MEM - 2);
  localparam int SET_W       = MAX_LOG_SETS;
  localparam int WAY_W       = 3;
  localparam int RANK_W      = 3;
  localparam int OIDX_W      = MAX_LOG_PHYS_MEM - 2;
  localparam int LRU_W       = MAX_WAYS * RANK_W;
  localparam int CQ_DEPTH    = 4;
  localparam int CQ_PTR_W    = 2;
  localparam int CQ_CNT_W    = 3;

  // Address modes
  localparam logic [1:0] MODE_PP = 2'd0;
  localparam logic [1:0] MODE_VP = 2'd1;
  localparam logic [1:0] MODE_VV = 2'd2;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_PAGE  = 3'd1,
    REG_PMEM  = 3'd2,
    REG_SETS  = 3'd3,
    REG_LINE  = 3'd4,
    REG_WAYS  = 3'd5
  } reg_idx_t;

  // Saturated configuration
  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] lp;
    logic [4:0] lm;
    logic [3:0] ls;
    logic [3:0] ll;
    logic [3:0] nw;
  } cfg_t;

  // Classified access handed from front to back
  typedef struct packed {
    logic              rd;
    logic              virt;
    logic [SET_W-1:0]  set;
    logic [31:0]       tag;
    logic [OIDX_W-1:0] oidx;
  } cmd_t;

  typedef struct packed {
    logic [SET_W-1:0] set;
    logic [WAY_W-1:0] way;
    logic             valid;
  } own_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic [63:0]      rreq;
    logic [63:0]      wreq;
    logic [63:0]      rhit;
    logic [63:0]      whit;
  } res_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_LOOK,
    B_FILL
  } bstate_t;

  // Reset ranks: rank equals way index
  function automatic logic [LRU_W-1:0] lru_init();
    logic [LRU_W-1:0] row;
    row = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      row[w*RANK_W +: RANK_W] = RANK_W'(w);
    end
    return row;
  endfunction

  // Move one way to most recent, age the younger ones
  function automatic logic [LRU_W-1:0] lru_touch(logic [LRU_W-1:0] row,
                                                 logic [WAY_W-1:0] way);
    logic [LRU_W-1:0]  res;
    logic [RANK_W-1:0] old;
    old = row[way*RANK_W +: RANK_W];
    res = row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (row[w*RANK_W +: RANK_W] < old) begin
        res[w*RANK_W +: RANK_W] = row[w*RANK_W +: RANK_W] + 1'b1;
      end
    end
    res[way*RANK_W +: RANK_W] = '0;
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/lruc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_front: address translation and classification
// Two-stage page hash and index/tag split, feeding a small command queue.
// ----------------------------------------------------------------------------
module lruc_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  lruc_pkg::cfg_t      cfg,
  input  wire                 hold,
  input  wire                 in_push,
  output logic                in_full,
  input  wire                 in_func,
  input  wire  [31:0]         in_virtual_address,
  input  wire                 cq_pop,
  output logic                cq_empty,
  output lruc_pkg::cmd_t      cq_head
);
  import lruc_pkg::*;

  logic        s1v_r;
  logic        s1_rd_r;
  logic [31:0] s1_va_r;
  logic [31:0] s1_k_r;

  cmd_t                cq_mem_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] cq_wp_r, cq_rp_r;
  logic [CQ_CNT_W-1:0] cq_cnt_r;

  logic        accept;
  logic [31:0] va_al, vpn, k0, k1, k2;
  logic [31:0] k3, k4, k5, lpmask, lmmask, pa, idx_a, tag_a, tmask, setv;
  logic [4:0]  sll;
  cmd_t        cmd;

  // Room is reserved for the item in the hash stage
  assign in_full  = hold | ((cq_cnt_r + CQ_CNT_W'(s1v_r)) >= CQ_CNT_W'(CQ_DEPTH));
  assign accept   = in_push & ~in_full;
  assign cq_empty = (cq_cnt_r == '0);
  assign cq_head  = cq_mem_r[cq_rp_r];

  // Hash, first half
  always_comb begin
    va_al = {in_virtual_address[31:2], 2'b00};
    vpn   = va_al >> cfg.lp;
    k0    = ~vpn + (vpn << 15);
    k1    = k0 ^ 32'($signed(k0) >>> 12);
    k2    = k1 + (k1 << 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1v_r <= 1'b0;
    end else begin
      s1v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd_r <= in_func;
      s1_va_r <= va_al;
      s1_k_r  <= k2;
    end
  end

  // Hash second half, physical address, set / tag / owner index
  always_comb begin
    k3     = s1_k_r ^ 32'($signed(s1_k_r) >>> 4);
    k4     = k3 + (k3 << 3) + (k3 << 11);
    k5     = k4 ^ 32'($signed(k4) >>> 16);
    lpmask = (32'd1 << cfg.lp) - 32'd1;
    lmmask = (32'd1 << cfg.lm) - 32'd1;
    pa     = ((s1_va_r & lpmask) + (k5 << cfg.lp)) & lmmask;
    idx_a  = (cfg.mode == MODE_PP) ? pa : s1_va_r;
    tag_a  = (cfg.mode == MODE_VV) ? s1_va_r : pa;
    sll    = 5'(cfg.ls) + 5'(cfg.ll);
    tmask  = ~((32'd1 << sll) - 32'd1);
    if (cfg.mode == MODE_VP && sll > cfg.lp) begin
      tmask = ~lpmask;
    end
    setv     = (idx_a >> cfg.ll) & ((32'd1 << cfg.ls) - 32'd1);
    cmd.rd   = s1_rd_r;
    cmd.virt = (cfg.mode != MODE_PP);
    cmd.set  = setv[SET_W-1:0];
    cmd.tag  = tag_a & tmask;
    // Owner index: line number wrapped to the table depth
    cmd.oidx = OIDX_W'(pa >> cfg.ll);
  end

  // Command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cq_wp_r  <= '0;
      cq_rp_r  <= '0;
      cq_cnt_r <= '0;
    end else begin
      if (s1v_r)  cq_wp_r <= cq_wp_r + 1'b1;
      if (cq_pop) cq_rp_r <= cq_rp_r + 1'b1;
      cq_cnt_r <= cq_cnt_r + CQ_CNT_W'(s1v_r) - CQ_CNT_W'(cq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1v_r) begin
      cq_mem_r[cq_wp_r] <= cmd;
    end
  end

endmodule
`default_nettype wire

/* rtl/lruc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_back: tag lookup, alias invalidation, fill and result queue
// Sequencer over per-way tag/valid memories, LRU row memory and owner table.
// ----------------------------------------------------------------------------
module lruc_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire  [3:0]              nw,
  input  wire                     cq_empty,
  input  lruc_pkg::cmd_t          cq_head,
  output logic                    cq_pop,
  output logic                    busy,
  output logic                    out_empty,
  input  wire                     out_pop,
  output logic                    out_hit,
  output logic [2:0]              out_way_used,
  output logic [63:0]             out_read_requests,
  output logic [63:0]             out_write_requests,
  output logic [63:0]             out_read_hits,
  output logic [63:0]             out_write_hits
);
  import lruc_pkg::*;

  // Storage
  logic              vmem [MAX_WAYS][NUM_SETS];
  logic [31:0]       tmem [MAX_WAYS][NUM_SETS];
  logic [LRU_W-1:0]  lmem [NUM_SETS];
  own_t              omem [OWNER_DEPTH];

  logic [MAX_WAYS-1:0] vrd_r, vld_r;
  logic [31:0]         trd_r [MAX_WAYS];
  logic [LRU_W-1:0]    lrd_r;
  own_t                ord_r;

  bstate_t           state_r, state_nxt;
  logic [OIDX_W-1:0] clr_cnt_r;
  cmd_t              cmd_r;
  logic [63:0]       rreq_r, wreq_r, rhit_r, whit_r;

  res_t        rq_mem_r [2];
  logic        rq_wp_r, rq_rp_r;
  logic [1:0]  rq_cnt_r;

  // Control
  logic                rd_en;
  logic [MAX_WAYS-1:0] vwe, vdin, twe;
  logic [SET_W-1:0]    vaddr;
  logic                lwe, owe;
  logic [SET_W-1:0]    laddr;
  logic [LRU_W-1:0]    ldin;
  logic [OIDX_W-1:0]   oaddr;
  own_t                odin;
  logic                push, res_hit, look_hit, inval;
  logic [WAY_W-1:0]    res_way, hway, fway;
  logic [MAX_WAYS-1:0] vloc;
  logic                found;
  logic [RANK_W-1:0]   best;

  assign busy = (state_r == B_CLEAR);

  // Hit search, first match among ways in use
  always_comb begin
    look_hit = 1'b0;
    hway     = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (4'(w) < nw && vrd_r[w] && trd_r[w] == cmd_r.tag) begin
        look_hit = 1'b1;
        hway     = WAY_W'(w);
      end
    end
    inval = ~look_hit & cmd_r.virt & ord_r.valid;
    vloc  = vrd_r;
    if (inval && ord_r.set == cmd_r.set) begin
      vloc[ord_r.way] = 1'b0;
    end
  end

  // Victim: first free way, else the oldest way in use
  always_comb begin
    found = 1'b0;
    fway  = '0;
    best  = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (4'(w) < nw && !vld_r[w]) begin
        found = 1'b1;
        fway  = WAY_W'(w);
      end
    end
    if (!found) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (4'(w) < nw && lrd_r[w*RANK_W +: RANK_W] >= best) begin
          best = lrd_r[w*RANK_W +: RANK_W];
          fway = WAY_W'(w);
        end
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    cq_pop    = 1'b0;
    vwe       = '0;
    vdin      = '0;
    vaddr     = cmd_r.set;
    twe       = '0;
    lwe       = 1'b0;
    laddr     = cmd_r.set;
    ldin      = lru_init();
    owe       = 1'b0;
    oaddr     = cmd_r.oidx;
    odin      = '0;
    push      = 1'b0;
    res_hit   = 1'b0;
    res_way   = '0;
    unique case (state_r)
      B_CLEAR: begin
        owe   = 1'b1;
        oaddr = clr_cnt_r;
        if (clr_cnt_r < OIDX_W'(NUM_SETS)) begin
          vwe   = '1;
          vaddr = clr_cnt_r[SET_W-1:0];
          lwe   = 1'b1;
          laddr = clr_cnt_r[SET_W-1:0];
        end
        if (clr_cnt_r == OIDX_W'(OWNER_DEPTH - 1)) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (!cq_empty && rq_cnt_r != 2'd2) begin
          cq_pop    = 1'b1;
          rd_en     = 1'b1;
          state_nxt = B_LOOK;
        end
      end
      B_LOOK: begin
        if (look_hit) begin
          lwe       = 1'b1;
          ldin      = lru_touch(lrd_r, hway);
          push      = 1'b1;
          res_hit   = 1'b1;
          res_way   = hway;
          state_nxt = B_IDLE;
        end else begin
          if (inval) begin
            vwe[ord_r.way] = 1'b1;
            vaddr          = ord_r.set;
          end
          state_nxt = B_FILL;
        end
      end
      B_FILL: begin
        vwe[fway]  = 1'b1;
        vdin[fway] = 1'b1;
        twe[fway]  = 1'b1;
        lwe        = 1'b1;
        ldin       = lru_touch(lrd_r, fway);
        owe        = 1'b1;
        odin.set   = cmd_r.set;
        odin.way   = fway;
        odin.valid = 1'b1;
        push       = 1'b1;
        res_way    = fway;
        state_nxt  = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Command capture and local valid copy for the fill
  always_ff @(posedge clk) begin
    if (rd_en) cmd_r <= cq_head;
    if (state_r == B_LOOK) vld_r <= vloc;
  end

  // Memories: registered reads, one write port each
  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        vrd_r[w] <= vmem[w][cq_head.set];
        trd_r[w] <= tmem[w][cq_head.set];
      end
      lrd_r <= lmem[cq_head.set];
      ord_r <= omem[cq_head.oidx];
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (vwe[w]) vmem[w][vaddr] <= vdin[w];
      if (twe[w]) tmem[w][cmd_r.set] <= cmd_r.tag;
    end
    if (lwe) lmem[laddr] <= ldin;
    if (owe) omem[oaddr] <= odin;
  end

  // Access counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rreq_r <= '0;
      wreq_r <= '0;
      rhit_r <= '0;
      whit_r <= '0;
    end else if (push) begin
      rreq_r <= rreq_r + 64'(cmd_r.rd);
      wreq_r <= wreq_r + 64'(!cmd_r.rd);
      rhit_r <= rhit_r + 64'(cmd_r.rd && res_hit);
      whit_r <= whit_r + 64'(!cmd_r.rd && res_hit);
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wp_r  <= 1'b0;
      rq_rp_r  <= 1'b0;
      rq_cnt_r <= '0;
    end else begin
      if (push) rq_wp_r <= ~rq_wp_r;
      if (out_pop && !out_empty) rq_rp_r <= ~rq_rp_r;
      rq_cnt_r <= rq_cnt_r + 2'(push) - 2'(out_pop && !out_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rq_mem_r[rq_wp_r].hit  <= res_hit;
      rq_mem_r[rq_wp_r].way  <= res_way;
      rq_mem_r[rq_wp_r].rreq <= rreq_r + 64'(cmd_r.rd);
      rq_mem_r[rq_wp_r].wreq <= wreq_r + 64'(!cmd_r.rd);
      rq_mem_r[rq_wp_r].rhit <= rhit_r + 64'(cmd_r.rd && res_hit);
      rq_mem_r[rq_wp_r].whit <= whit_r + 64'(!cmd_r.rd && res_hit);
    end
  end

  assign out_empty          = (rq_cnt_r == 2'd0);
  assign out_hit            = rq_mem_r[rq_rp_r].hit;
  assign out_way_used       = rq_mem_r[rq_rp_r].way;
  assign out_read_requests  = rq_mem_r[rq_rp_r].rreq;
  assign out_write_requests = rq_mem_r[rq_rp_r].wreq;
  assign out_read_hits      = rq_mem_r[rq_rp_r].rhit;
  assign out_write_hits     = rq_mem_r[rq_rp_r].whit;

endmodule
`default_nettype wire

/* rtl/lru_cache_with_alias_invalidation.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_cache_with_alias_invalidation: set-associative true-LRU tag cache
// Requests (read/write + virtual address) enter through a push/full queue
// port; one result per request leaves through an empty/pop queue port.
// The front translates and classifies via a registered hash stage into a
// 4-entry command queue. The back takes one request at a time: a hit does a
// lookup read; a miss adds an alias invalidation write and a fill write, kept
// apart by the single write port of the valid/tag/LRU/owner memories. Results
// wait in a 2-entry queue; when the receiver stalls the back stops once that
// queue is full and the front keeps filling until full rises. After reset the
// block clears the owner table, valid bits and LRU ranks, one entry per cycle
// over 16384 owner entries, with full high meanwhile. Configuration is written
// via cfg_we/cfg_index/cfg_wdata while idle; the user must ensure this.
// ----------------------------------------------------------------------------
module lru_cache_with_alias_invalidation (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [4:0]  cfg_wdata,
  input  wire         in_push,
  output logic        in_full,
  input  wire         in_func,
  input  wire  [31:0] in_virtual_address,
  output logic        out_empty,
  input  wire         out_pop,
  output logic        out_hit,
  output logic [2:0]  out_way_used,
  output logic [63:0] out_read_requests,
  output logic [63:0] out_write_requests,
  output logic [63:0] out_read_hits,
  output logic [63:0] out_write_hits
);
  import lruc_pkg::*;

  logic [1:0] mode_r;
  logic [4:0] lp_r, lm_r;
  logic [3:0] ls_r, ll_r, nw_r;
  cfg_t       cfg;
  logic       busy, cq_empty, cq_pop;
  cmd_t       cq_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 2'd0;
      lp_r   <= 5'd12;
      lm_r   <= 5'd16;
      ls_r   <= 4'd11;
      ll_r   <= 4'd2;
      nw_r   <= 4'd1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE: mode_r <= cfg_wdata[1:0];
        REG_PAGE: lp_r   <= cfg_wdata;
        REG_PMEM: lm_r   <= cfg_wdata;
        REG_SETS: ls_r   <= cfg_wdata[3:0];
        REG_LINE: ll_r   <= cfg_wdata[3:0];
        REG_WAYS: nw_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Saturate out-of-range settings
  always_comb begin
    cfg.mode = (mode_r > MODE_VV) ? MODE_VV : mode_r;
    cfg.lp   = (lp_r < 5'd2) ? 5'd2 : ((lp_r > 5'd16) ? 5'd16 : lp_r);
    cfg.lm   = (lm_r < 5'd4) ? 5'd4 :
               ((lm_r > 5'(MAX_LOG_PHYS_MEM)) ? 5'(MAX_LOG_PHYS_MEM) : lm_r);
    cfg.ls   = (ls_r > 4'(MAX_LOG_SETS)) ? 4'(MAX_LOG_SETS) : ls_r;
    cfg.ll   = (ll_r < 4'd2) ? 4'd2 : ((ll_r > 4'd8) ? 4'd8 : ll_r);
    cfg.nw   = (nw_r < 4'd1) ? 4'd1 :
               ((nw_r > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : nw_r);
  end

  lruc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .hold               (busy),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_func            (in_func),
    .in_virtual_address (in_virtual_address),
    .cq_pop             (cq_pop),
    .cq_empty           (cq_empty),
    .cq_head            (cq_head)
  );

  lruc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .nw                 (cfg.nw),
    .cq_empty           (cq_empty),
    .cq_head            (cq_head),
    .cq_pop             (cq_pop),
    .busy               (busy),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_hit            (out_hit),
    .out_way_used       (out_way_used),
    .out_read_requests  (out_read_requests),
    .out_write_requests (out_write_requests),
    .out_read_hits      (out_read_hits),
    .out_write_hits     (out_write_hits)
  );

endmodule
`default_nettype wire
